// File: rtl/gamepad_poll_sequencer_assert.svh
// Assertion macros shared by the reply memory and top-level modules of the gamepad poll sequencer
`ifndef GAMEPAD_POLL_SEQUENCER_ASSERT_SVH
`define GAMEPAD_POLL_SEQUENCER_ASSERT_SVH

// Clocked check, suspended while reset is held
`define GPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define GPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/gps_pkg.sv
// Shared types, constants and frame tables of the gamepad poll sequencer
`default_nettype none

package gps_pkg;

    // Reply bytes stored from one poll frame
    localparam int POLL_FRAME_BYTES_DEF = 21;
    // Widest position counter any legal frame length needs
    localparam int POS_MAX_W = 6;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANALOG_LOCK = 4'd3;

    // Register reset values
    localparam logic [7:0] HALF_BIT_RST    = 8'd2;
    localparam logic [7:0] BYTE_GAP_RST    = 8'd10;
    localparam logic [7:0] FRAME_GAP_RST   = 8'd4;
    localparam logic [7:0] ANALOG_LOCK_RST = 8'd3;

    // Link bytes
    localparam logic [7:0] CMD_START   = 8'h01;
    localparam logic [7:0] CMD_POLL    = 8'h42;
    localparam logic [7:0] CMD_CONFIG  = 8'h43;
    localparam logic [7:0] CMD_ANALOG  = 8'h44;
    localparam logic [7:0] PAD_EXIT    = 8'h5A;
    localparam logic [7:0] MODE_MASK   = 8'hF0;
    localparam logic [7:0] MODE_ANALOG = 8'h70;
    localparam logic [15:0] BTN_NONE   = 16'hFFFF;

    // Configuration frames
    localparam logic [7:0] ENTER_SEQ [5] = '{CMD_START, CMD_CONFIG, 8'h00, 8'h01, 8'h00};
    localparam logic [7:0] ANALOG_SEQ [9] = '{CMD_START, CMD_ANALOG, 8'h00, 8'h01,
                                              ANALOG_LOCK_RST, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] EXIT_SEQ [9] = '{CMD_START, CMD_CONFIG, 8'h00, 8'h00,
                                            PAD_EXIT, PAD_EXIT, PAD_EXIT, PAD_EXIT, PAD_EXIT};

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_LOW       = 5'b00010,
        PH_HIGH      = 5'b00100,
        PH_BYTEGAP   = 5'b01000,
        PH_FRAMEGAP  = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        FK_POLL   = 2'd0,
        FK_ENTER  = 2'd1,
        FK_ANALOG = 2'd2,
        FK_EXIT   = 2'd3
    } t_frame;

    // Pin levels and busy flag for one tick
    typedef struct packed {
        logic clk_lvl;
        logic cmd_lvl;
        logic att_lvl;
        logic busy;
    } t_pins;

    // Byte to shift out at a position of a frame
    function automatic logic [7:0] gps_tx_byte(t_frame kind, logic [POS_MAX_W-1:0] pos,
                                               logic [7:0] lock);
        logic [7:0] b;
        b = 8'h00;
        unique case (kind)
            FK_POLL: begin
                if (pos == 6'd0) b = CMD_START;
                else if (pos == 6'd1) b = CMD_POLL;
            end
            FK_ENTER: begin
                if (pos < 6'd5) b = ENTER_SEQ[pos[2:0]];
            end
            FK_ANALOG: begin
                if (pos == 6'd4) b = lock;
                else if (pos < 6'd9) b = ANALOG_SEQ[pos[3:0]];
            end
            default: begin
                if (pos < 6'd9) b = EXIT_SEQ[pos[3:0]];
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gps_if.sv
// Valid/ready channel interfaces of the gamepad poll sequencer
`default_nettype none

// Tick input channel
interface gps_in_if;
    logic       valid;
    logic       ready;
    logic       dat_level;
    logic       start_poll;
    logic [4:0] analog_index;

    modport source (output valid, output dat_level, output start_poll,
                    output analog_index, input ready);
    modport sink (input valid, input dat_level, input start_poll,
                  input analog_index, output ready);
endinterface

// Result output channel
interface gps_out_if;
    logic        valid;
    logic        ready;
    logic        clk_level;
    logic        cmd_level;
    logic        att_level;
    logic        busy_res;
    logic        poll_done;
    logic [15:0] buttons_held;
    logic [15:0] buttons_changed;
    logic [15:0] buttons_pressed;
    logic [15:0] buttons_released;
    logic [7:0]  analog_value;

    modport source (output valid, output clk_level, output cmd_level, output att_level,
                    output busy_res, output poll_done, output buttons_held,
                    output buttons_changed, output buttons_pressed,
                    output buttons_released, output analog_value, input ready);
    modport sink (input valid, input clk_level, input cmd_level, input att_level,
                  input busy_res, input poll_done, input buttons_held,
                  input buttons_changed, input buttons_pressed,
                  input buttons_released, input analog_value, output ready);
endinterface

// Register write channel
interface gps_cfg_if;
    import gps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gps_reply_mem.sv
// Reply byte memory with registered read, write forwarding and per-entry valid bits
`default_nettype none
`include "gamepad_poll_sequencer_assert.svh"

module gps_reply_mem #(
    parameter int DEPTH  = gps_pkg::POLL_FRAME_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [7:0]        i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_rd_inr,
    output logic [7:0]             o_rd_data
);
    import gps_pkg::*;

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_fwd_data;
    logic             r_rd_valid;
    logic             r_fwd;
    logic             r_rd_inr;
    logic             hit;

    assign hit = i_wr_en && (i_wr_addr == i_rd_addr);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark written entries; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en && i_rd_inr) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_rd_inr   <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_inr   <= i_rd_inr;
            r_fwd      <= hit;
            r_rd_valid <= i_rd_inr && r_valid[i_rd_addr];
        end
    end

    // Pick forwarded, stored or zero data
    always_comb begin
        if (!r_rd_inr) begin
            o_rd_data = 8'h00;
        end else if (r_fwd) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_valid) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = 8'h00;
        end
    end

    `GPS_ASSERT(a_wr_on_step, i_wr_en |-> i_rd_en, "write outside a tick")
    `GPS_ASSERT(a_fwd_data, i_rd_en && i_rd_inr && hit |=> o_rd_data == $past(i_wr_data), "read missed same-tick write")
    `GPS_ASSERT(a_hold_rd, !i_rd_en |=> $stable(o_rd_data), "read data moved without a read")

endmodule

`default_nettype wire

// File: rtl/gps_link_ctrl.sv
// Link sequencer: tick counting, bit shifting, frame sequencing and button latch
`default_nettype none

module gps_link_ctrl #(
    parameter int POLL_FRAME_BYTES = gps_pkg::POLL_FRAME_BYTES_DEF,
    parameter int ADDR_W           = $clog2(POLL_FRAME_BYTES)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic                           i_dat,
    input  wire logic                           i_start,
    input  wire logic                           i_cfg_we,
    input  wire logic [gps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gps_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output gps_pkg::t_pins                      o_pins,
    output logic                                o_done,
    output logic [15:0]                         o_btn_now,
    output logic [15:0]                         o_btn_before,
    output logic                                o_wr_en,
    output logic [ADDR_W-1:0]                   o_wr_addr,
    output logic [7:0]                          o_wr_data
);
    import gps_pkg::*;

    localparam int LEN_MAX = (POLL_FRAME_BYTES > 9) ? POLL_FRAME_BYTES : 9;
    localparam int POS_W   = $clog2(LEN_MAX + 1);

    // Configuration registers
    logic [7:0] r_half_bit, r_byte_gap, r_frame_gap, r_lock;

    // Sequencer state
    t_phase     r_phase, n_phase;
    t_frame     r_kind, n_kind;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_rx, n_rx;
    logic [7:0] r_sh1, n_sh1, r_sh3, n_sh3, r_sh4, n_sh4;
    logic [15:0] r_now, n_now, r_before, n_before;
    logic       r_done, n_done;

    logic [7:0] half;
    logic [7:0] tick_inc;
    logic [7:0] tx;
    logic [POS_W-1:0] frame_len;
    logic       wr_en, do_end_byte, do_end_frame, do_start;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit  <= HALF_BIT_RST;
            r_byte_gap  <= BYTE_GAP_RST;
            r_frame_gap <= FRAME_GAP_RST;
            r_lock      <= ANALOG_LOCK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALF_BIT:    r_half_bit  <= i_cfg_data;
                REG_BYTE_GAP:    r_byte_gap  <= i_cfg_data;
                REG_FRAME_GAP:   r_frame_gap <= i_cfg_data;
                REG_ANALOG_LOCK: r_lock      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign half     = (r_half_bit == 8'd0) ? 8'd1 : r_half_bit;
    assign tick_inc = r_tick + 8'd1;
    assign tx       = gps_tx_byte(r_kind, POS_MAX_W'(r_pos), r_lock);

    always_comb begin
        unique case (r_kind)
            FK_POLL:  frame_len = POS_W'(POLL_FRAME_BYTES);
            FK_ENTER: frame_len = POS_W'(5);
            default:  frame_len = POS_W'(9);
        endcase
    end

    // Pin levels from the state at the start of the tick
    always_comb begin
        o_pins = '{clk_lvl: 1'b1, cmd_lvl: 1'b1, att_lvl: 1'b1, busy: 1'b1};
        unique case (r_phase)
            PH_LOW: begin
                o_pins.clk_lvl = 1'b0;
                o_pins.cmd_lvl = tx[r_bit];
                o_pins.att_lvl = 1'b0;
            end
            PH_HIGH: begin
                o_pins.cmd_lvl = tx[r_bit];
                o_pins.att_lvl = 1'b0;
            end
            PH_BYTEGAP: begin
                o_pins.att_lvl = 1'b0;
            end
            PH_FRAMEGAP: ;
            default: begin
                o_pins.busy = 1'b0;
            end
        endcase
    end

    // Next state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_pos        = r_pos;
        n_bit        = r_bit;
        n_tick       = r_tick;
        n_rx         = r_rx;
        n_sh1        = r_sh1;
        n_sh3        = r_sh3;
        n_sh4        = r_sh4;
        n_now        = r_now;
        n_before     = r_before;
        n_done       = 1'b0;
        wr_en        = 1'b0;
        do_end_byte  = 1'b0;
        do_end_frame = 1'b0;
        do_start     = 1'b0;

        unique case (r_phase)
            PH_LOW: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    if (i_dat) n_rx[r_bit] = 1'b1;
                    n_tick  = 8'd0;
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                n_tick = tick_inc;
                if (tick_inc >= half) begin
                    n_tick = 8'd0;
                    if (r_bit == 3'd7) begin
                        // store the poll reply byte and keep the header bytes at hand
                        if (r_kind == FK_POLL) begin
                            wr_en = 1'b1;
                            if (r_pos == POS_W'(1)) n_sh1 = r_rx;
                            if (r_pos == POS_W'(3)) n_sh3 = r_rx;
                            if (r_pos == POS_W'(4)) n_sh4 = r_rx;
                        end
                        n_bit = 3'd0;
                        if (r_byte_gap == 8'd0) do_end_byte = 1'b1;
                        else n_phase = PH_BYTEGAP;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_LOW;
                    end
                end
            end
            PH_BYTEGAP: begin
                n_tick = tick_inc;
                if (tick_inc >= r_byte_gap) do_end_byte = 1'b1;
            end
            PH_FRAMEGAP: begin
                n_tick = tick_inc;
                if (tick_inc >= r_frame_gap) do_start = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_start) begin
                    n_kind   = FK_POLL;
                    do_start = 1'b1;
                end
            end
        endcase

        // Advance to the next byte or close the frame
        if (do_end_byte) begin
            n_pos = r_pos + POS_W'(1);
            if (n_pos < frame_len) begin
                n_bit   = 3'd0;
                n_tick  = 8'd0;
                n_rx    = 8'd0;
                n_phase = PH_LOW;
            end else begin
                do_end_frame = 1'b1;
            end
        end

        // Latch buttons on a good reply, else walk the reconfiguration frames
        if (do_end_frame) begin
            if (r_kind == FK_POLL && (n_sh1 & MODE_MASK) == MODE_ANALOG) begin
                n_before = r_now;
                n_now    = {n_sh4, n_sh3};
                n_done   = 1'b1;
                n_phase  = PH_IDLE;
                n_tick   = 8'd0;
                n_pos    = '0;
                n_bit    = 3'd0;
            end else begin
                unique case (r_kind)
                    FK_POLL:   n_kind = FK_ENTER;
                    FK_ENTER:  n_kind = FK_ANALOG;
                    FK_ANALOG: n_kind = FK_EXIT;
                    default:   n_kind = FK_POLL;
                endcase
                n_tick = 8'd0;
                if (r_frame_gap == 8'd0) do_start = 1'b1;
                else n_phase = PH_FRAMEGAP;
            end
        end

        // Open a frame
        if (do_start) begin
            n_pos   = '0;
            n_bit   = 3'd0;
            n_tick  = 8'd0;
            n_rx    = 8'd0;
            n_phase = PH_LOW;
        end
    end

    // State registers advance once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kind   <= FK_POLL;
            r_pos    <= '0;
            r_bit    <= 3'd0;
            r_tick   <= 8'd0;
            r_rx     <= 8'd0;
            r_sh1    <= 8'd0;
            r_sh3    <= 8'd0;
            r_sh4    <= 8'd0;
            r_now    <= BTN_NONE;
            r_before <= BTN_NONE;
            r_done   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_pos    <= n_pos;
            r_bit    <= n_bit;
            r_tick   <= n_tick;
            r_rx     <= n_rx;
            r_sh1    <= n_sh1;
            r_sh3    <= n_sh3;
            r_sh4    <= n_sh4;
            r_now    <= n_now;
            r_before <= n_before;
            r_done   <= n_done;
        end
    end

    assign o_done       = r_done;
    assign o_btn_now    = r_now;
    assign o_btn_before = r_before;
    assign o_wr_en      = wr_en && i_step;
    assign o_wr_addr    = r_pos[ADDR_W-1:0];
    assign o_wr_data    = r_rx;

endmodule

`default_nettype wire

// File: rtl/gamepad_poll_sequencer.sv
// Top level of the gamepad poll sequencer: handshakes, result register, link control and reply memory
`default_nettype none
`include "gamepad_poll_sequencer_assert.svh"

// Gamepad poll sequencer. Each input beat is one tick of the serial link and yields exactly
// one result beat. A new tick is taken every clock cycle as long as the result of the previous
// tick is taken at the same time or the result slot is empty, so the sustained rate is one
// tick per cycle; a result appears in the cycle after its tick is accepted. The reply
// memory's read at analog_index is registered, and a reply byte written on the same
// tick is forwarded. Pin levels and busy_res give the state at the start of the tick;
// poll_done, the button masks and analog_value give the state after it. Registers are to
// be written through the configuration channel only while no tick is in flight (the block
// does not enforce this); the channel is always ready and ignores indexes past REG_ANALOG_LOCK.
module gamepad_poll_sequencer #(
    parameter int POLL_FRAME_BYTES = gps_pkg::POLL_FRAME_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gps_in_if.sink     i_in,
    gps_cfg_if.sink    i_cfg,
    gps_out_if.source  o_out
);
    import gps_pkg::*;

    localparam int ADDR_W = $clog2(POLL_FRAME_BYTES);

    logic              step;
    logic              rd_inr;
    t_pins             pins;
    t_pins             r_pins;
    logic              r_out_valid;
    logic              done;
    logic [15:0]       btn_now, btn_before, held, changed;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    // Take a tick whenever the result slot frees up this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign rd_inr     = int'(i_in.analog_index) < POLL_FRAME_BYTES;

    gps_link_ctrl #(
        .POLL_FRAME_BYTES (POLL_FRAME_BYTES),
        .ADDR_W           (ADDR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_dat        (i_in.dat_level),
        .i_start      (i_in.start_poll),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_idx    (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_pins       (pins),
        .o_done       (done),
        .o_btn_now    (btn_now),
        .o_btn_before (btn_before),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    gps_reply_mem #(
        .DEPTH  (POLL_FRAME_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (step),
        .i_rd_addr (i_in.analog_index[ADDR_W-1:0]),
        .i_rd_inr  (rd_inr),
        .o_rd_data (rd_data)
    );

    // Result slot: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_pins <= pins;
        end
    end

    // Button masks from the latched words (active low on the link)
    assign held    = ~btn_now;
    assign changed = btn_now ^ btn_before;

    assign o_out.valid            = r_out_valid;
    assign o_out.clk_level        = r_pins.clk_lvl;
    assign o_out.cmd_level        = r_pins.cmd_lvl;
    assign o_out.att_level        = r_pins.att_lvl;
    assign o_out.busy_res         = r_pins.busy;
    assign o_out.poll_done        = done;
    assign o_out.buttons_held     = held;
    assign o_out.buttons_changed  = changed;
    assign o_out.buttons_pressed  = changed & held;
    assign o_out.buttons_released = changed & ~btn_before;
    assign o_out.analog_value     = rd_data;

    `GPS_ASSERT(a_step_gives_beat, step |=> o_out.valid, "accepted tick produced no result")
    `GPS_ASSERT(a_done_busy, o_out.valid && o_out.poll_done |-> o_out.busy_res, "poll done outside a frame")
    `GPS_ASSERT(a_att_busy, o_out.valid && !o_out.att_level |-> o_out.busy_res, "attention low while idle")
    `GPS_ASSERT_ALWAYS(a_rst_empty, !$past(i_rst_n) |-> !o_out.valid, "result slot not cleared by reset")

endmodule

`default_nettype wire

// File: tb/gamepad_poll_sequencer_tb.sv
// Self-checking testbench for the gamepad poll sequencer: link predictor, tick driver, result monitor
`timescale 1ns / 100ps

module gamepad_poll_sequencer_tb;
    import gps_pkg::*;

    localparam int POLL_BYTES  = POLL_FRAME_BYTES_DEF;
    localparam int QUIET_LIMIT = 2000;

    // Link state as the predictor keeps it, configuration included
    typedef struct packed {
        t_phase                      phase;
        t_frame                      kind;
        logic [5:0]                  byte_pos;
        logic [2:0]                  bit_pos;
        logic [7:0]                  ticks;
        logic [7:0]                  shift;
        logic [POLL_BYTES-1:0][7:0]  replies;
        logic [15:0]                 btn_now;
        logic [15:0]                 btn_prev;
        logic [7:0]                  half_bit;
        logic [7:0]                  byte_gap;
        logic [7:0]                  frame_gap;
        logic [7:0]                  lock;
    } t_link_state;

    // One input beat
    typedef struct packed {
        logic       dat;
        logic       req;
        logic [4:0] idx;
    } t_tick;

    // One output beat
    typedef struct packed {
        logic        clk;
        logic        cmd;
        logic        att;
        logic        busy;
        logic        done;
        logic [15:0] held;
        logic [15:0] changed;
        logic [15:0] pressed;
        logic [15:0] released;
        logic [7:0]  value;
    } t_tick_result;

    logic i_clk;
    logic i_rst_n;

    gps_in_if  in_if ();
    gps_out_if out_if ();
    gps_cfg_if cfg_if ();

    gamepad_poll_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_link_state  link_now;
    t_link_state  link_plan;
    t_tick        pending_ticks[$];
    t_tick_result due_results[$];

    int  mismatches = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  quiet_cycles = 0;
    int  stall_mode = 0;
    int  cycle_count = 0;
    int  bad_polls_left = 0;
    bit  force_good = 0;
    logic [7:0] pad_reply = 8'h00;

    // Generate the clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Byte shifted out at the current frame position
    function automatic logic [7:0] tx_byte_at(input t_link_state s);
        logic [7:0] b;
        b = 8'h00;
        if (s.byte_pos == 6'd0) begin
            b = CMD_START;
        end else begin
            case (s.kind)
                FK_POLL: begin
                    if (s.byte_pos == 6'd1) b = CMD_POLL;
                end
                FK_ENTER: begin
                    if (s.byte_pos == 6'd1) b = CMD_CONFIG;
                    else if (s.byte_pos == 6'd3) b = 8'h01;
                end
                FK_ANALOG: begin
                    if (s.byte_pos == 6'd1) b = CMD_ANALOG;
                    else if (s.byte_pos == 6'd3) b = 8'h01;
                    else if (s.byte_pos == 6'd4) b = s.lock;
                end
                default: begin
                    if (s.byte_pos == 6'd1) b = CMD_CONFIG;
                    else if (s.byte_pos >= 6'd4 && s.byte_pos < 6'd9) b = PAD_EXIT;
                end
            endcase
        end
        return b;
    endfunction

    function automatic logic [5:0] frame_bytes(input t_frame kind);
        if (kind == FK_POLL) return 6'(POLL_BYTES);
        if (kind == FK_ENTER) return 6'd5;
        return 6'd9;
    endfunction

    // Begin a frame at its first bit
    task automatic open_frame(inout t_link_state s);
        s.byte_pos = 6'd0;
        s.bit_pos  = 3'd0;
        s.ticks    = 8'd0;
        s.shift    = 8'd0;
        s.phase    = PH_LOW;
    endtask

    // Advance to the next byte; at the end of a frame, latch buttons or step the config chain
    task automatic finish_byte(inout t_link_state s, inout logic done);
        s.byte_pos = s.byte_pos + 6'd1;
        if (s.byte_pos < frame_bytes(s.kind)) begin
            s.bit_pos = 3'd0;
            s.ticks   = 8'd0;
            s.shift   = 8'd0;
            s.phase   = PH_LOW;
        end else if (s.kind == FK_POLL && (s.replies[1] & MODE_MASK) == MODE_ANALOG) begin
            s.btn_prev = s.btn_now;
            s.btn_now  = {s.replies[4], s.replies[3]};
            done       = 1'b1;
            s.phase    = PH_IDLE;
            s.ticks    = 8'd0;
            s.byte_pos = 6'd0;
            s.bit_pos  = 3'd0;
        end else begin
            case (s.kind)
                FK_POLL:   s.kind = FK_ENTER;
                FK_ENTER:  s.kind = FK_ANALOG;
                FK_ANALOG: s.kind = FK_EXIT;
                default:   s.kind = FK_POLL;
            endcase
            s.ticks = 8'd0;
            if (s.frame_gap == 8'd0) open_frame(s);
            else s.phase = PH_FRAMEGAP;
        end
    endtask

    // Predict one tick of the link and the result it shows
    task automatic advance_link(inout t_link_state s, input t_tick t, output t_tick_result r);
        logic [7:0] half;
        logic [7:0] txb;
        logic       done;
        half = (s.half_bit == 8'd0) ? 8'd1 : s.half_bit;
        txb  = tx_byte_at(s);
        done = 1'b0;
        r = '0;
        r.clk  = 1'b1;
        r.cmd  = 1'b1;
        r.att  = 1'b1;
        r.busy = 1'b1;
        case (s.phase)
            PH_LOW: begin
                r.clk = 1'b0;
                r.cmd = txb[s.bit_pos];
                r.att = 1'b0;
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= half) begin
                    if (t.dat) s.shift[s.bit_pos] = 1'b1;
                    s.ticks = 8'd0;
                    s.phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                r.cmd = txb[s.bit_pos];
                r.att = 1'b0;
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= half) begin
                    s.ticks = 8'd0;
                    if (s.bit_pos == 3'd7) begin
                        if (s.kind == FK_POLL && s.byte_pos < 6'(POLL_BYTES))
                            s.replies[s.byte_pos] = s.shift;
                        s.bit_pos = 3'd0;
                        if (s.byte_gap == 8'd0) finish_byte(s, done);
                        else s.phase = PH_BYTEGAP;
                    end else begin
                        s.bit_pos = s.bit_pos + 3'd1;
                        s.phase   = PH_LOW;
                    end
                end
            end
            PH_BYTEGAP: begin
                r.att = 1'b0;
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= s.byte_gap) finish_byte(s, done);
            end
            PH_FRAMEGAP: begin
                s.ticks = s.ticks + 8'd1;
                if (s.ticks >= s.frame_gap) open_frame(s);
            end
            default: begin
                r.busy  = 1'b0;
                s.phase = PH_IDLE;
                if (t.req) begin
                    s.kind = FK_POLL;
                    open_frame(s);
                end
            end
        endcase
        r.done     = done;
        r.held     = ~s.btn_now;
        r.changed  = s.btn_now ^ s.btn_prev;
        r.pressed  = r.changed & r.held;
        r.released = r.changed & ~s.btn_prev;
        r.value    = (t.idx < 5'(POLL_BYTES)) ? s.replies[t.idx] : 8'h00;
    endtask

    // Queue one tick; the pad answers with a chosen byte on every sampling tick
    task automatic plan_tick(input logic req, input logic [4:0] idx);
        logic [7:0]   half;
        logic [3:0]   nib;
        logic [3:0]   hi;
        bit           good;
        t_tick        t;
        t_tick_result ignored;
        half = (link_plan.half_bit == 8'd0) ? 8'd1 : link_plan.half_bit;
        if (link_plan.phase == PH_LOW && link_plan.bit_pos == 3'd0 && link_plan.ticks == 8'd0) begin
            nib = 4'($urandom_range(0, 15));
            if (link_plan.kind == FK_POLL && link_plan.byte_pos == 6'd1) begin
                if (force_good) begin
                    good = 1'b1;
                end else if (bad_polls_left > 0) begin
                    good = 1'b0;
                    bad_polls_left--;
                end else begin
                    good = ($urandom_range(0, 3) != 0);
                end
                hi = 4'($urandom_range(0, 14));
                if (hi >= 4'd7) hi = hi + 4'd1;
                pad_reply = good ? {4'h7, nib} : {hi, nib};
            end else begin
                pad_reply = 8'($urandom);
            end
        end
        t.dat = 1'($urandom_range(0, 1));
        if (link_plan.phase == PH_LOW && ({1'b0, link_plan.ticks} + 9'd1) >= {1'b0, half})
            t.dat = pad_reply[link_plan.bit_pos];
        t.req = req;
        t.idx = idx;
        pending_ticks.push_back(t);
        advance_link(link_plan, t, ignored);
    endtask

    // Queue random ticks until the target is met and, unless cut short, the link is idle
    task automatic run_phase(input int target, input int bad_first, input bit cut_short);
        int         count;
        logic       req;
        logic [4:0] idx;
        count = 0;
        bad_polls_left = bad_first;
        force_good = 1'b0;
        forever begin
            if (count >= target) begin
                force_good = 1'b1;
                if (cut_short || link_plan.phase == PH_IDLE) break;
            end
            if (link_plan.phase == PH_IDLE) req = ($urandom_range(0, 2) == 0);
            else req = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0) idx = 5'($urandom_range(21, 31));
            else idx = 5'($urandom_range(0, 20));
            plan_tick(req, idx);
            count++;
        end
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_HALF_BIT:    link_now.half_bit  = value;
            REG_BYTE_GAP:    link_now.byte_gap  = value;
            REG_FRAME_GAP:   link_now.frame_gap = value;
            REG_ANALOG_LOCK: link_now.lock      = value;
            default: ;
        endcase
    endtask

    // Hold until every tick has been shown, then let the last one settle
    task automatic drain_link();
        while (pending_ticks.size() != 0 || in_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Reconfigure at idle and restart planning from the predictor
    task automatic begin_phase(input logic [7:0] half, input logic [7:0] bgap,
                               input logic [7:0] fgap, input logic [7:0] lock);
        drain_link();
        write_reg(REG_HALF_BIT, half);
        write_reg(REG_BYTE_GAP, bgap);
        write_reg(REG_FRAME_GAP, fgap);
        write_reg(REG_ANALOG_LOCK, lock);
        link_plan = link_now;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Drive ticks in bursts and predict each accepted beat
    always @(posedge i_clk) begin
        t_tick        seen;
        t_tick        next;
        t_tick_result res;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.dat_level    <= 1'b0;
            in_if.start_poll   <= 1'b0;
            in_if.analog_index <= 5'd0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                seen.dat = in_if.dat_level;
                seen.req = in_if.start_poll;
                seen.idx = in_if.analog_index;
                advance_link(link_now, seen, res);
                due_results.push_back(res);
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    next = pending_ticks.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.dat_level    <= next.dat;
                    in_if.start_poll   <= next.req;
                    in_if.analog_index <= next.idx;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 300 : 30);
                        gap_left   = $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Check each result beat against the oldest prediction; stall on a changing pattern
    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none actual %0h",
                             $time, out_if.buttons_held);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("clk_level", 16'(want.clk), 16'(out_if.clk_level));
                    check_field("cmd_level", 16'(want.cmd), 16'(out_if.cmd_level));
                    check_field("att_level", 16'(want.att), 16'(out_if.att_level));
                    check_field("busy_res", 16'(want.busy), 16'(out_if.busy_res));
                    check_field("poll_done", 16'(want.done), 16'(out_if.poll_done));
                    check_field("buttons_held", want.held, out_if.buttons_held);
                    check_field("buttons_changed", want.changed, out_if.buttons_changed);
                    check_field("buttons_pressed", want.pressed, out_if.buttons_pressed);
                    check_field("buttons_released", want.released, out_if.buttons_released);
                    check_field("analog_value", 16'(want.value), 16'(out_if.analog_value));
                end
            end
            cycle_count++;
            if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= cycle_count[0];
                2:       out_if.ready <= ($urandom_range(0, 9) < 7);
                default: out_if.ready <= ((cycle_count % 7) >= 3);
            endcase
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Reset, then run the directed ticks and the random phases
    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.dat_level    = 1'b0;
        in_if.start_poll   = 1'b0;
        in_if.analog_index = 5'd0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;

        link_now           = '0;
        link_now.phase     = PH_IDLE;
        link_now.kind      = FK_POLL;
        link_now.btn_now   = BTN_NONE;
        link_now.btn_prev  = BTN_NONE;
        link_now.half_bit  = HALF_BIT_RST;
        link_now.byte_gap  = BYTE_GAP_RST;
        link_now.frame_gap = FRAME_GAP_RST;
        link_now.lock      = ANALOG_LOCK_RST;
        link_plan          = link_now;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle reads at the index extremes, a taken request, requests while busy
        plan_tick(1'b0, 5'd0);
        plan_tick(1'b0, 5'd20);
        plan_tick(1'b0, 5'd21);
        plan_tick(1'b0, 5'd31);
        plan_tick(1'b1, 5'd5);
        plan_tick(1'b1, 5'd0);
        plan_tick(1'b1, 5'd31);
        plan_tick(1'b1, 5'd20);
        for (int i = 0; i < 8; i++) plan_tick(1'b0, 5'(i * 4));
        run_phase(0, 0, 1'b0);

        // Fastest bits with no gaps; first poll fails the mode check; unknown indexes ignored
        begin_phase(8'd1, 8'd0, 8'd0, 8'd0);
        write_reg(4'd7, 8'hFF);
        write_reg(4'd15, 8'h00);
        link_plan = link_now;
        run_phase(400, 1, 1'b0);

        // Zero half-bit count acts as one
        begin_phase(8'd0, 8'd1, 8'd1, 8'hFF);
        run_phase(300, 0, 1'b0);

        // Longest frame gap through the whole config chain
        begin_phase(8'd1, 8'd0, 8'd255, 8'hA5);
        run_phase(50, 1, 1'b0);

        // Longest bit halves and byte gap, cut off mid-frame
        begin_phase(8'd255, 8'd255, 8'd255, 8'($urandom));
        run_phase(4500, 0, 1'b1);

        drain_link();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/gps_pkg.sv
rtl/gps_if.sv
rtl/gps_reply_mem.sv
rtl/gps_link_ctrl.sv
rtl/gamepad_poll_sequencer.sv
tb/gamepad_poll_sequencer_tb.sv
